// File: rtl/gbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gbs_pkg;

    localparam int FRAC_BITS = 32;
    localparam int NUM_SHIFT = (3 * FRAC_BITS >= 64) ? (3 * FRAC_BITS - 64) : 0;
    localparam int DEN_SHIFT = (3 * FRAC_BITS >= 64) ? 0 : (64 - 3 * FRAC_BITS);

    localparam int GC_W   = 40;
    localparam int MASS_W = 31;
    localparam int GM_W   = GC_W + MASS_W;
    localparam int PROD_W = 192;
    localparam int NUM_W  = GM_W + 64 + NUM_SHIFT;
    localparam int DEN_W  = PROD_W + DEN_SHIFT;
    localparam int QUO_W  = 63;
    localparam int HI_W   = NUM_W - QUO_W;
    localparam int CMP_W  = ((HI_W > DEN_W) ? HI_W : DEN_W) + 1;

    localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;

    localparam logic [39:0] GC_RESET = 40'd1231107000;

    // Input kinds.
    localparam logic [1:0] KIND_NEIGHBOR     = 2'd0;
    localparam logic [1:0] KIND_NEIGHBOR_END = 2'd1;
    localparam logic [1:0] KIND_END          = 2'd2;
    localparam logic [1:0] KIND_UNUSED       = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_START_X    = 2'd0;
    localparam logic [1:0] CFG_START_Y    = 2'd1;
    localparam logic [1:0] CFG_GRAV_CONST = 2'd2;
    localparam logic [1:0] CFG_UNUSED     = 2'd3;

    // Multiplier jobs.
    typedef logic [2:0] mul_op_t;
    localparam mul_op_t MUL_DX2 = 3'd0;
    localparam mul_op_t MUL_DY2 = 3'd1;
    localparam mul_op_t MUL_DEN = 3'd2;
    localparam mul_op_t MUL_GM  = 3'd3;
    localparam mul_op_t MUL_NX  = 3'd4;
    localparam mul_op_t MUL_NY  = 3'd5;

    typedef struct packed {
        logic    load;
        logic    diff;
        logic    coin;
        logic    mul_start;
        mul_op_t mul_op;
        logic    sqrt_start;
        logic    div_start;
        logic    acc;
        logic    vel;
        logic    pos1;
        logic    out;
    } cmd_t;

    typedef struct packed {
        logic zero_dist;
        logic mul_done;
        logic sqrt_done;
        logic div_done;
    } status_t;

    // Result in the low 64 bits, overflow flag on top.
    function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        logic        ovf;
        s   = a + b;
        ovf = (a[63] == b[63]) && (s[63] != a[63]);
        return ovf ? {1'b1, (a[63] ? NEG_MIN : POS_MAX)} : {1'b0, s};
    endfunction

    function automatic logic [64:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] d;
        logic        ovf;
        d   = a - b;
        ovf = (a[63] != b[63]) && (d[63] != a[63]);
        return ovf ? {1'b1, (a[63] ? NEG_MIN : POS_MAX)} : {1'b0, d};
    endfunction

endpackage
`default_nettype wire

// File: rtl/gbs_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// 128 x 64 multiplier built from one 32 x 32 product per cycle.
module gbs_mul (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [127:0] a,
    input  wire logic [63:0]  b,
    output logic              done,
    output logic [191:0]      p
);

    logic [127:0] a_reg;
    logic [63:0]  b_reg;
    logic [2:0]   cnt_reg;
    logic         run_reg;
    logic [63:0]  pp_reg;
    logic [2:0]   pp_sh_reg;
    logic         pp_v_reg;
    logic         pp_last_reg;
    logic         done_reg;
    logic [191:0] acc_reg;
    logic [191:0] acc_next;
    logic [31:0]  a_limb;
    logic [31:0]  b_limb;

    assign a_limb   = a_reg[{cnt_reg[1:0], 5'b0} +: 32];
    assign b_limb   = b_reg[{cnt_reg[2], 5'b0} +: 32];
    assign acc_next = acc_reg + ({128'b0, pp_reg} << {pp_sh_reg, 5'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= 1'b0;
            pp_v_reg    <= 1'b0;
            pp_last_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else if (start)
        begin
            run_reg     <= 1'b1;
            pp_v_reg    <= 1'b0;
            pp_last_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            pp_v_reg    <= run_reg;
            pp_last_reg <= run_reg && (cnt_reg == 3'd7);
            done_reg    <= pp_v_reg && pp_last_reg;
            if (run_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else
        begin
            pp_reg    <= a_limb * b_limb;
            pp_sh_reg <= {1'b0, cnt_reg[1:0]} + {2'b0, cnt_reg[2]};
            if (pp_v_reg)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule
`default_nettype wire

// File: rtl/gbs_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// Floor square root of a 128-bit value, two radicand bits per cycle.
module gbs_sqrt (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [127:0] n,
    output logic              done,
    output logic [63:0]       root
);

    logic [127:0] n_reg;
    logic [65:0]  rem_reg;
    logic [63:0]  root_reg;
    logic [5:0]   cnt_reg;
    logic         run_reg;
    logic         done_reg;
    logic [67:0]  rem_sh;
    logic [67:0]  trial;
    logic         fits;

    assign rem_sh = {rem_reg, n_reg[127:126]};
    assign trial  = {2'b0, root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == 6'd63);
            if (run_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg    <= n;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (run_reg)
        begin
            n_reg <= {n_reg[125:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= 66'(rem_sh - trial);
                root_reg <= {root_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[65:0];
                root_reg <= {root_reg[62:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

// File: rtl/gbs_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider that yields a 63-bit quotient or an overflow mark.
// Overflow is decided up front; the 63 steps then run either way.
module gbs_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [gbs_pkg::NUM_W-1:0]  num,
    input  wire logic [gbs_pkg::DEN_W-1:0]  den,
    output logic                            done,
    output logic                            ovf,
    output logic [gbs_pkg::QUO_W-1:0]       q
);

    logic [gbs_pkg::DEN_W-1:0] den_reg;
    logic [gbs_pkg::DEN_W-1:0] rem_reg;
    logic [gbs_pkg::QUO_W-1:0] rq_reg;
    logic                      ovf_reg;
    logic [5:0]                cnt_reg;
    logic                      run_reg;
    logic                      done_reg;
    logic [gbs_pkg::DEN_W:0]   rem_sh;
    logic                      fits;

    assign rem_sh = {rem_reg, rq_reg[gbs_pkg::QUO_W-1]};
    assign fits   = (rem_sh >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == 6'(gbs_pkg::QUO_W - 1));
            if (run_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(gbs_pkg::QUO_W - 1))
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            ovf_reg <= (gbs_pkg::CMP_W'(num[gbs_pkg::NUM_W-1:gbs_pkg::QUO_W])
                        >= gbs_pkg::CMP_W'(den));
            rem_reg <= gbs_pkg::DEN_W'(num[gbs_pkg::NUM_W-1:gbs_pkg::QUO_W]);
            rq_reg  <= num[gbs_pkg::QUO_W-1:0];
        end
        else if (run_reg)
        begin
            if (fits)
            begin
                rem_reg <= gbs_pkg::DEN_W'(rem_sh - {1'b0, den_reg});
            end
            else
            begin
                rem_reg <= rem_sh[gbs_pkg::DEN_W-1:0];
            end
            rq_reg <= {rq_reg[gbs_pkg::QUO_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign ovf  = ovf_reg;
    assign q    = rq_reg;

endmodule
`default_nettype wire

// File: rtl/gbs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module gbs_datapath (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire gbs_pkg::cmd_t    cmd,
    output gbs_pkg::status_t      status,
    input  wire logic [159:0]     in_data,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [63:0]      cfg_data,
    output logic [255:0]          out_data,
    output logic [1:0]            out_user
);

    // Body state and configuration.
    logic [63:0] start_x_reg, start_x_next;
    logic [63:0] start_y_reg, start_y_next;
    logic [39:0] gc_reg, gc_next;
    logic        cfg_hit;
    logic [63:0] pos_x_reg, pos_y_reg;
    logic [63:0] vel_x_reg, vel_y_reg;
    logic [63:0] acc_x_reg, acc_y_reg;
    logic        coin_reg;
    logic        sat_reg;
    gbs_pkg::mul_op_t mul_op_reg;

    // Per-neighbor working values.
    logic [63:0]              nx_reg, ny_reg;
    logic [30:0]              mass_reg;
    logic [63:0]              dx_reg, dy_reg;
    logic [127:0]             r2_reg;
    logic [191:0]             den_reg;
    logic [gbs_pkg::GM_W-1:0] gm_reg;
    logic [gbs_pkg::NUM_W-1:0] numx_reg, numy_reg;
    logic [63:0]              tmp_x_reg, tmp_y_reg;
    logic [255:0]             out_data_reg;
    logic [1:0]               out_user_reg;

    logic [64:0]  dx_res, dy_res;
    logic [63:0]  mag_dx, mag_dy;
    logic [127:0] mul_a;
    logic [63:0]  mul_b;
    logic         mul_done;
    logic [191:0] mul_p;
    logic         sqrt_done;
    logic [63:0]  root;
    logic         divx_done, divy_done;
    logic         ovf_x, ovf_y;
    logic [62:0]  q_x, q_y;
    logic [63:0]  mag_px, mag_py, term_x, term_y;
    logic [64:0]  accx_res, accy_res;
    logic [64:0]  velx_res, vely_res;
    logic [64:0]  p1x_res, p1y_res;
    logic [64:0]  finx_res, finy_res;
    logic         sat_hit;

    assign dx_res = gbs_pkg::sat_sub(nx_reg, pos_x_reg);
    assign dy_res = gbs_pkg::sat_sub(ny_reg, pos_y_reg);
    assign mag_dx = dx_reg[63] ? 64'(-dx_reg) : dx_reg;
    assign mag_dy = dy_reg[63] ? 64'(-dy_reg) : dy_reg;

    always_comb
    begin
        mul_a = 128'(mag_dx);
        mul_b = mag_dx;
        unique case (cmd.mul_op)
            gbs_pkg::MUL_DX2:
            begin
                mul_a = 128'(mag_dx);
                mul_b = mag_dx;
            end
            gbs_pkg::MUL_DY2:
            begin
                mul_a = 128'(mag_dy);
                mul_b = mag_dy;
            end
            gbs_pkg::MUL_DEN:
            begin
                mul_a = r2_reg;
                mul_b = root;
            end
            gbs_pkg::MUL_GM:
            begin
                mul_a = 128'(gc_reg);
                mul_b = 64'(mass_reg);
            end
            gbs_pkg::MUL_NX:
            begin
                mul_a = 128'(gm_reg);
                mul_b = mag_dx;
            end
            gbs_pkg::MUL_NY:
            begin
                mul_a = 128'(gm_reg);
                mul_b = mag_dy;
            end
            default:
            begin
                mul_a = 128'(mag_dx);
                mul_b = mag_dx;
            end
        endcase
    end

    gbs_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    gbs_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.sqrt_start),
        .n     (r2_reg),
        .done  (sqrt_done),
        .root  (root)
    );

    gbs_div u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (numx_reg),
        .den   (gbs_pkg::DEN_W'(den_reg) << gbs_pkg::DEN_SHIFT),
        .done  (divx_done),
        .ovf   (ovf_x),
        .q     (q_x)
    );

    gbs_div u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (numy_reg),
        .den   (gbs_pkg::DEN_W'(den_reg) << gbs_pkg::DEN_SHIFT),
        .done  (divy_done),
        .ovf   (ovf_y),
        .q     (q_y)
    );

    // The pull takes the sign of the offset on its axis.
    assign mag_px = ovf_x ? gbs_pkg::POS_MAX : {1'b0, q_x};
    assign mag_py = ovf_y ? gbs_pkg::POS_MAX : {1'b0, q_y};
    assign term_x = dx_reg[63] ? 64'(-mag_px) : mag_px;
    assign term_y = dy_reg[63] ? 64'(-mag_py) : mag_py;

    assign accx_res = gbs_pkg::sat_add(acc_x_reg, term_x);
    assign accy_res = gbs_pkg::sat_add(acc_y_reg, term_y);
    assign velx_res = gbs_pkg::sat_add(vel_x_reg, acc_x_reg);
    assign vely_res = gbs_pkg::sat_add(vel_y_reg, acc_y_reg);
    assign p1x_res  = gbs_pkg::sat_add(pos_x_reg, vel_x_reg);
    assign p1y_res  = gbs_pkg::sat_add(pos_y_reg, vel_y_reg);
    assign finx_res = gbs_pkg::sat_add(tmp_x_reg, {acc_x_reg[63], acc_x_reg[63:1]});
    assign finy_res = gbs_pkg::sat_add(tmp_y_reg, {acc_y_reg[63], acc_y_reg[63:1]});

    assign sat_hit = (cmd.diff && (dx_res[64] || dy_res[64]))
                   || (cmd.acc && (ovf_x || ovf_y || accx_res[64] || accy_res[64]))
                   || (cmd.vel && (velx_res[64] || vely_res[64]))
                   || (cmd.pos1 && (p1x_res[64] || p1y_res[64]));

    always_comb
    begin
        start_x_next = start_x_reg;
        start_y_next = start_y_reg;
        gc_next      = gc_reg;
        cfg_hit      = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                gbs_pkg::CFG_START_X:
                begin
                    start_x_next = cfg_data;
                    cfg_hit      = 1'b1;
                end
                gbs_pkg::CFG_START_Y:
                begin
                    start_y_next = cfg_data;
                    cfg_hit      = 1'b1;
                end
                gbs_pkg::CFG_GRAV_CONST:
                begin
                    gc_next = cfg_data[39:0];
                    cfg_hit = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            gc_reg      <= gbs_pkg::GC_RESET;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            vel_x_reg   <= '0;
            vel_y_reg   <= '0;
            acc_x_reg   <= '0;
            acc_y_reg   <= '0;
            coin_reg    <= 1'b0;
            sat_reg     <= 1'b0;
            mul_op_reg  <= gbs_pkg::MUL_DX2;
        end
        else
        begin
            start_x_reg <= start_x_next;
            start_y_reg <= start_y_next;
            gc_reg      <= gc_next;
            if (cmd.mul_start)
            begin
                mul_op_reg <= cmd.mul_op;
            end
            if (cfg_hit)
            begin
                pos_x_reg <= start_x_next;
                pos_y_reg <= start_y_next;
                vel_x_reg <= '0;
                vel_y_reg <= '0;
            end
            if (cmd.coin)
            begin
                coin_reg <= 1'b1;
            end
            if (cmd.acc)
            begin
                acc_x_reg <= accx_res[63:0];
                acc_y_reg <= accy_res[63:0];
            end
            if (cmd.vel)
            begin
                vel_x_reg <= velx_res[63:0];
                vel_y_reg <= vely_res[63:0];
            end
            if (cmd.out)
            begin
                pos_x_reg <= finx_res[63:0];
                pos_y_reg <= finy_res[63:0];
                acc_x_reg <= '0;
                acc_y_reg <= '0;
                coin_reg  <= 1'b0;
                sat_reg   <= 1'b0;
            end
            else if (sat_hit)
            begin
                sat_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            nx_reg   <= in_data[63:0];
            ny_reg   <= in_data[127:64];
            mass_reg <= in_data[158:128];
        end
        if (cmd.diff)
        begin
            dx_reg <= dx_res[63:0];
            dy_reg <= dy_res[63:0];
        end
        if (mul_done)
        begin
            unique case (mul_op_reg)
                gbs_pkg::MUL_DX2: r2_reg   <= mul_p[127:0];
                gbs_pkg::MUL_DY2: r2_reg   <= r2_reg + mul_p[127:0];
                gbs_pkg::MUL_DEN: den_reg  <= mul_p;
                gbs_pkg::MUL_GM:  gm_reg   <= mul_p[gbs_pkg::GM_W-1:0];
                gbs_pkg::MUL_NX:  numx_reg <= gbs_pkg::NUM_W'(mul_p[gbs_pkg::GM_W+63:0])
                                              << gbs_pkg::NUM_SHIFT;
                gbs_pkg::MUL_NY:  numy_reg <= gbs_pkg::NUM_W'(mul_p[gbs_pkg::GM_W+63:0])
                                              << gbs_pkg::NUM_SHIFT;
                default:          r2_reg   <= r2_reg;
            endcase
        end
        if (cmd.pos1)
        begin
            tmp_x_reg <= p1x_res[63:0];
            tmp_y_reg <= p1y_res[63:0];
        end
        if (cmd.out)
        begin
            out_data_reg <= {pos_y_reg, pos_x_reg, finy_res[63:0], finx_res[63:0]};
            out_user_reg <= {sat_reg || finx_res[64] || finy_res[64], coin_reg};
        end
    end

    assign status.zero_dist = (dx_reg == 64'd0) && (dy_reg == 64'd0);
    assign status.mul_done  = mul_done;
    assign status.sqrt_done = sqrt_done;
    assign status.div_done  = divx_done && divy_done;

    assign out_data = out_data_reg;
    assign out_user = out_user_reg;

endmodule
`default_nettype wire

// File: rtl/gbs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module gbs_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        in_kind,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output gbs_pkg::cmd_t          cmd,
    input  wire gbs_pkg::status_t  status
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_DIFF = 5'd1;
    localparam logic [4:0] S_CHK  = 5'd2;
    localparam logic [4:0] S_MDX  = 5'd3;
    localparam logic [4:0] S_MDY  = 5'd4;
    localparam logic [4:0] S_SQS  = 5'd5;
    localparam logic [4:0] S_SQW  = 5'd6;
    localparam logic [4:0] S_MDEN = 5'd7;
    localparam logic [4:0] S_MGM  = 5'd8;
    localparam logic [4:0] S_MNX  = 5'd9;
    localparam logic [4:0] S_MNY  = 5'd10;
    localparam logic [4:0] S_DIVS = 5'd11;
    localparam logic [4:0] S_DIVW = 5'd12;
    localparam logic [4:0] S_ACC  = 5'd13;
    localparam logic [4:0] S_VEL  = 5'd14;
    localparam logic [4:0] S_POS1 = 5'd15;
    localparam logic [4:0] S_OUT  = 5'd16;
    localparam logic [4:0] S_DIVG = 5'd17;

    logic [4:0] state_reg, state_next;
    logic       end_reg, end_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       slot_free;

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        end_next   = end_reg;
        cmd        = '0;
        cmd.mul_op = gbs_pkg::MUL_DX2;
        cmd.load   = accept;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_kind)
                        gbs_pkg::KIND_NEIGHBOR:
                        begin
                            end_next   = 1'b0;
                            state_next = S_DIFF;
                        end
                        gbs_pkg::KIND_NEIGHBOR_END:
                        begin
                            end_next   = 1'b1;
                            state_next = S_DIFF;
                        end
                        gbs_pkg::KIND_END:
                        begin
                            state_next = S_VEL;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (status.zero_dist)
                begin
                    cmd.coin   = 1'b1;
                    state_next = end_reg ? S_VEL : S_IDLE;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = gbs_pkg::MUL_DX2;
                    state_next    = S_MDX;
                end
            end
            S_MDX:
            begin
                if (status.mul_done)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = gbs_pkg::MUL_DY2;
                    state_next    = S_MDY;
                end
            end
            S_MDY:
            begin
                if (status.mul_done)
                begin
                    state_next = S_SQS;
                end
            end
            S_SQS:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = S_SQW;
            end
            S_SQW:
            begin
                if (status.sqrt_done)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = gbs_pkg::MUL_DEN;
                    state_next    = S_MDEN;
                end
            end
            S_MDEN:
            begin
                if (status.mul_done)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = gbs_pkg::MUL_GM;
                    state_next    = S_MGM;
                end
            end
            S_MGM:
            begin
                if (status.mul_done)
                begin
                    state_next = S_MNX;
                end
            end
            S_MNX:
            begin
                // Started in the cycle after the mass product has landed.
                cmd.mul_start = 1'b1;
                cmd.mul_op    = gbs_pkg::MUL_NX;
                state_next    = S_MNY;
            end
            S_MNY:
            begin
                if (status.mul_done)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = gbs_pkg::MUL_NY;
                    state_next    = S_DIVS;
                end
            end
            S_DIVS:
            begin
                if (status.mul_done)
                begin
                    state_next = S_DIVG;
                end
            end
            S_DIVG:
            begin
                // The dividers start on the beat after the second numerator lands.
                cmd.div_start = 1'b1;
                state_next    = S_DIVW;
            end
            S_DIVW:
            begin
                if (status.div_done)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = end_reg ? S_VEL : S_IDLE;
            end
            S_VEL:
            begin
                cmd.vel    = 1'b1;
                state_next = S_POS1;
            end
            S_POS1:
            begin
                cmd.pos1   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    cmd.out    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            end_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            end_reg       <= end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// File: rtl/gravity_body_step.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Beat contents
// s_axis    in         tuser kind; tdata neighbor_x, neighbor_y, neighbor_mass
// m_axis    out        tdata new_x, new_y, prev_x, prev_y; tuser coincident, saturated
// cfg       in         write enable, register index, 64-bit write data
//
// A neighbor beat is taken only once the last one is done: six multiplies on the
// shared 32 x 32 multiplier, the 64 square-root steps, the 63 steps of the two
// dividers that run side by side, and single control states. An end step adds the
// velocity and position updates plus any wait for m_axis_tready. A zero-distance
// neighbor skips the arithmetic; kind 2 runs only the end step; kind 3 is dropped.
// rst_n clears the body state at once; no clearing pass is needed.
// A finished result waits in the output register; the next beat is taken meanwhile.
module gravity_body_step (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [159:0] s_axis_tdata,  // neighbor_x, neighbor_y, neighbor_mass, pad
    input  wire logic [1:0]   s_axis_tuser,  // kind
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [255:0]      m_axis_tdata,  // new_x, new_y, prev_x, prev_y
    output logic [1:0]        m_axis_tuser,  // coincident, saturated
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [63:0]  cfg_data
);

    gbs_pkg::cmd_t    cmd;
    gbs_pkg::status_t status;

    gbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_kind   (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .status    (status)
    );

    gbs_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_axis_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser)
    );

    // A pending result is never overwritten.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result loaded over a pending beat");

    // No arithmetic unit starts while a new beat can be taken.
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !(cmd.mul_start || cmd.sqrt_start || cmd.div_start))
        else $error("unit started while idle");

    // The dividers only ever see a nonzero distance.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !status.zero_dist)
        else $error("division started for a coincident neighbor");

endmodule
`default_nettype wire

// File: sim/gbs_checker.sv
`timescale 1ns / 1ps
module gbs_checker
    import gbs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [159:0] s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [255:0] m_axis_tdata,
    input  logic [1:0]   m_axis_tuser,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    output int           steps_pending,
    output int           steps_checked,
    output int           errors
);

    typedef struct packed {
        logic [63:0] new_x;
        logic [63:0] new_y;
        logic [63:0] prev_x;
        logic [63:0] prev_y;
        logic        coincident;
        logic        saturated;
    } step_result_t;

    step_result_t step_q[$];

    logic [63:0] st_x, st_y;
    logic [39:0] g_scaled;
    logic [63:0] px, py, vx, vy, ax, ay;
    logic        seen_coin, seen_sat;

    function automatic logic [63:0] add_clamp(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
        begin
            seen_sat = 1'b1;
            return a[63] ? NEG_MIN : POS_MAX;
        end
        return s;
    endfunction

    function automatic logic [63:0] sub_clamp(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] d;
        d = a - b;
        if (a[63] != b[63] && d[63] != a[63])
        begin
            seen_sat = 1'b1;
            return a[63] ? NEG_MIN : POS_MAX;
        end
        return d;
    endfunction

    function automatic logic [63:0] abs64(input logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    function automatic logic [63:0] root_floor(input logic [255:0] n);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [255:0] sq;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            c  = r | (64'd1 << b);
            sq = {192'd0, c} * {192'd0, c};
            if (sq <= n)
                r = c;
        end
        return r;
    endfunction

    // Signed pull term G*m*d/(r^2*r) in the body's fixed-point format.
    function automatic logic [63:0] pull_term(input logic [255:0] gm, input logic [255:0] den_in,
                                              input logic [63:0] d);
        logic [255:0] num, den, quo;
        logic [63:0]  mag;
        num = gm * {192'd0, abs64(d)};
        den = den_in;
        if (3 * FRAC_BITS >= 64)
            num = num << (3 * FRAC_BITS - 64);
        else
            den = den << (64 - 3 * FRAC_BITS);
        quo = num / den;
        if (quo > {192'd0, POS_MAX})
        begin
            seen_sat = 1'b1;
            mag = POS_MAX;
        end
        else
            mag = quo[63:0];
        return d[63] ? (~mag + 64'd1) : mag;
    endfunction

    function automatic void apply_neighbor(input logic [63:0] nx, input logic [63:0] ny,
                                           input logic [30:0] mass);
        logic [63:0]  dx, dy;
        logic [255:0] r2, den, gm;
        dx = sub_clamp(nx, px);
        dy = sub_clamp(ny, py);
        if (dx == '0 && dy == '0)
        begin
            seen_coin = 1'b1;
            return;
        end
        r2  = {192'd0, abs64(dx)} * {192'd0, abs64(dx)}
            + {192'd0, abs64(dy)} * {192'd0, abs64(dy)};
        den = r2 * {192'd0, root_floor(r2)};
        gm  = {216'd0, g_scaled} * {225'd0, mass};
        ax  = add_clamp(ax, pull_term(gm, den, dx));
        ay  = add_clamp(ay, pull_term(gm, den, dy));
    endfunction

    function automatic step_result_t finish_step();
        step_result_t r;
        r.prev_x = px;
        r.prev_y = py;
        vx = add_clamp(vx, ax);
        vy = add_clamp(vy, ay);
        px = add_clamp(add_clamp(px, vx), {ax[63], ax[63:1]});
        py = add_clamp(add_clamp(py, vy), {ay[63], ay[63:1]});
        r.new_x      = px;
        r.new_y      = py;
        r.coincident = seen_coin;
        r.saturated  = seen_sat;
        ax = '0;
        ay = '0;
        seen_coin = 1'b0;
        seen_sat  = 1'b0;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
        end
    endtask

    assign steps_pending = step_q.size();

    initial
    begin
        errors        = 0;
        steps_checked = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        step_result_t want;
        step_result_t fresh;
        if (!rst_n)
        begin
            st_x = '0; st_y = '0; g_scaled = GC_RESET;
            px = '0; py = '0; vx = '0; vy = '0; ax = '0; ay = '0;
            seen_coin = 1'b0; seen_sat = 1'b0;
            step_q.delete();
        end
        else
        begin
            if (cfg_we && cfg_index != CFG_UNUSED)
            begin
                case (cfg_index)
                    CFG_START_X:    st_x = cfg_data;
                    CFG_START_Y:    st_y = cfg_data;
                    CFG_GRAV_CONST: g_scaled = cfg_data[39:0];
                    default:        ;
                endcase
                px = st_x; py = st_y; vx = '0; vy = '0;
            end
            // A result can never belong to the beat accepted at the same edge.
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (step_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result beat, actual %h %h", $realtime,
                             m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    want = step_q.pop_front();
                    steps_checked++;
                    compare_field("new_x", want.new_x, m_axis_tdata[63:0]);
                    compare_field("new_y", want.new_y, m_axis_tdata[127:64]);
                    compare_field("prev_x", want.prev_x, m_axis_tdata[191:128]);
                    compare_field("prev_y", want.prev_y, m_axis_tdata[255:192]);
                    compare_field("coincident", 64'(want.coincident), 64'(m_axis_tuser[0]));
                    compare_field("saturated", 64'(want.saturated), 64'(m_axis_tuser[1]));
                end
            end
            if (s_axis_tvalid && s_axis_tready && s_axis_tuser != KIND_UNUSED)
            begin
                if (s_axis_tuser != KIND_END)
                    apply_neighbor(s_axis_tdata[63:0], s_axis_tdata[127:64],
                                   s_axis_tdata[158:128]);
                if (s_axis_tuser != KIND_NEIGHBOR)
                begin
                    fresh  = finish_step();
                    step_q = {step_q, fresh};
                end
            end
        end
    end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import gbs_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [159:0] s_axis_tdata;   // neighbor_x, neighbor_y, neighbor_mass, pad
    logic [1:0]   s_axis_tuser;   // kind
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [255:0] m_axis_tdata;   // new_x, new_y, prev_x, prev_y
    logic [1:0]   m_axis_tuser;   // coincident, saturated
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [63:0]  cfg_data;

    int          steps_pending;
    int          steps_checked;
    int          errors;
    int          items_sent;
    int          phases_run;
    bit          gaps_on;
    logic [63:0] base_x, base_y;

    gravity_body_step uut (.*);

    gbs_checker body_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge clk)
        m_axis_tready <= gaps_on ? ($urandom_range(0, 99) >= 36) : 1'b1;

    task automatic send_beat(input logic [1:0] kind, input logic [63:0] nx,
                             input logic [63:0] ny, input logic [30:0] mass);
        bit ready_seen;
        while (gaps_on && $urandom_range(0, 99) < 36)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {1'b0, mass, ny, nx};
        // Ready is sampled mid-cycle so the edge that takes the beat is known.
        do
        begin
            @(negedge clk);
            ready_seen = s_axis_tready;
            @(posedge clk);
        end
        while (!ready_seen);
        if (kind != KIND_UNUSED)
            items_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (steps_pending != 0)
            @(posedge clk);
        // A trailing neighbor beat may still be in flight without a result.
        repeat (400) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return POS_MAX;
            1:       return NEG_MIN;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    function automatic logic [63:0] pick_coord(input logic [63:0] around);
        logic [63:0] off;
        case ($urandom_range(0, 9))
            0:       return pick_extreme();
            1, 2:    return {$urandom, $urandom};
            3:       return around;
            default:
            begin
                off = {{24{1'b0}}, 8'($urandom), $urandom};
                if ($urandom_range(0, 1))
                    off = ~off + 64'd1;
                return around + off;
            end
        endcase
    endfunction

    function automatic logic [30:0] pick_mass();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 31'($urandom_range(1, 1000));
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic random_step();
        int n;
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++)
            send_beat(KIND_NEIGHBOR, pick_coord(base_x), pick_coord(base_y), pick_mass());
        case ($urandom_range(0, 9))
            0:       send_beat(KIND_UNUSED, {$urandom, $urandom}, {$urandom, $urandom},
                               31'($urandom));
            1, 2, 3: send_beat(KIND_END, {$urandom, $urandom}, {$urandom, $urandom}, 31'($urandom));
            default: send_beat(KIND_NEIGHBOR_END, pick_coord(base_x), pick_coord(base_y),
                               pick_mass());
        endcase
    endtask

    initial
    begin
        logic [39:0] g;
        rst_n         = 1'b0;
        gaps_on       = 1'b1;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_NEIGHBOR;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_START_X;
        cfg_data      = '0;
        items_sent    = 0;
        phases_run    = 0;
        base_x        = '0;
        base_y        = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats under reset settings.
        send_beat(KIND_END, '0, '0, '0);
        send_beat(KIND_NEIGHBOR_END, '0, '0, '1);
        send_beat(KIND_NEIGHBOR, 64'h1_0000_0000, '0, '1);
        send_beat(KIND_NEIGHBOR, '0, 64'hFFFF_FFFF_0000_0000, 31'd12345);
        send_beat(KIND_NEIGHBOR_END, POS_MAX, NEG_MIN, '1);
        send_beat(KIND_UNUSED, '1, '1, '1);
        send_beat(KIND_NEIGHBOR, NEG_MIN, POS_MAX, '0);
        send_beat(KIND_END, '0, '0, '0);
        send_beat(KIND_NEIGHBOR, 64'd1, '0, '1);
        send_beat(KIND_NEIGHBOR_END, '0, 64'd1, '1);
        send_beat(KIND_END, '0, '0, '0);
        send_beat(KIND_NEIGHBOR_END, '1, '1, '1);
        send_beat(KIND_END, '0, '0, '0);
        drain();

        // Start at the (POS_MAX, NEG_MIN) corner and pull from the opposite one.
        write_reg(CFG_START_X, POS_MAX);
        write_reg(CFG_START_Y, NEG_MIN);
        write_reg(CFG_GRAV_CONST, 40'hFF_FFFF_FFFF);
        send_beat(KIND_NEIGHBOR_END, NEG_MIN, POS_MAX, '1);
        send_beat(KIND_NEIGHBOR_END, POS_MAX, NEG_MIN, '1);
        send_beat(KIND_END, '0, '0, '0);
        drain();

        while (items_sent < 1900)
        begin
            phases_run++;
            case ($urandom_range(0, 4))
                0:       base_x = pick_extreme();
                1:       base_x = {$urandom, $urandom};
                default: base_x = {{16{1'b0}}, 16'($urandom), $urandom} - 64'h0000_8000_0000_0000;
            endcase
            case ($urandom_range(0, 4))
                0:       base_y = pick_extreme();
                1:       base_y = {$urandom, $urandom};
                default: base_y = {{16{1'b0}}, 16'($urandom), $urandom} - 64'h0000_8000_0000_0000;
            endcase
            case ($urandom_range(0, 5))
                0:       g = '0;
                1:       g = '1;
                2:       g = {8'($urandom), $urandom};
                default: g = GC_RESET;
            endcase
            write_reg(CFG_START_X, base_x);
            write_reg(CFG_START_Y, base_y);
            write_reg(CFG_GRAV_CONST, g);
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_UNUSED, {$urandom, $urandom});
            for (int k = 0; k < 30 && items_sent < 1900; k++)
            begin
                gaps_on = !(items_sent >= 800 && items_sent < 1100);
                random_step();
            end
            drain();
        end

        gaps_on = 1'b1;
        drain();
        $display("Sent %0d beats over %0d register settings; %0d step results compared.",
                 items_sent, phases_run + 2, steps_checked);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: filelist.f
rtl/gbs_pkg.sv
rtl/gbs_mul.sv
rtl/gbs_sqrt.sv
rtl/gbs_div.sv
rtl/gbs_datapath.sv
rtl/gbs_ctrl.sv
rtl/gravity_body_step.sv
sim/gbs_checker.sv
sim/testbench.sv
